FILE: rtl/core/firmware_image_header_checker_macros.svh
// Assertion macros for the firmware image header checker.
// Included by the top level; no other dependencies.
`ifndef FIRMWARE_IMAGE_HEADER_CHECKER_MACROS_SVH
`define FIRMWARE_IMAGE_HEADER_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FIH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fih assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define FIH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fih assertion failed");

`else

`define FIH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FIH_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/core/fih_pkg.sv
// Shared types, constants and the byte-wide CRC step of the image header checker.
// No dependencies.
package fih_pkg;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SMALL    = 3'd1;
    localparam logic [2:0] ST_MAGIC    = 3'd2;
    localparam logic [2:0] ST_SIZE     = 3'd3;
    localparam logic [2:0] ST_CRC      = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_MIN_IMAGE  = 2'd0;
    localparam logic [1:0] REG_HEADER     = 2'd1;
    localparam logic [1:0] REG_SIZE_OFF   = 2'd2;
    localparam logic [1:0] REG_CRC_OFF    = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] MIN_IMAGE_RST = 16'h1000;
    localparam logic [11:0] HEADER_RST    = 12'h200;
    localparam logic [11:0] SIZE_OFF_RST  = 12'h184;
    localparam logic [11:0] CRC_OFF_RST   = 12'h18c;

    // CRC-32/MPEG-2 constants.
    localparam logic [31:0] CRC_POLY = 32'h04c11db7;
    localparam logic [31:0] CRC_INIT = 32'hffffffff;

    // Magic "LCFG" in file order.
    localparam logic [7:0] MAGIC [4] = '{8'h4c, 8'h43, 8'h46, 8'h47};

    // Queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One classified item as it travels from the front to the back end.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        magic_bad;
        logic        size_hit;
        logic [1:0]  size_rel;
        logic        crcw_hit;
        logic [1:0]  crcw_rel;
        logic        crc_en;
        logic        too_small;
        logic        short4;
        logic        saturated;
        logic [31:0] length;
    } q_entry_t;

    // One byte of CRC-32/MPEG-2, MSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Replace one byte of a little-endian word.
    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] rel,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        case (rel)
            2'd0:    r[7:0]   = b;
            2'd1:    r[15:8]  = b;
            2'd2:    r[23:16] = b;
            default: r[31:24] = b;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/fih_front.sv
// Front end of the image header checker: accepts bytes, tracks the byte position
// and classifies each item for the back end. Depends on fih_pkg.
module fih_front #(
    parameter int COUNT_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_data,
    input  logic                in_last,
    input  logic [15:0]         min_image_bytes,
    input  logic [11:0]         header_bytes,
    input  logic [11:0]         size_word_offset,
    input  logic [11:0]         crc_word_offset,
    input  logic                q_full,
    output logic                q_push,
    output fih_pkg::q_entry_t   q_data
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    logic [COUNT_BITS-1:0] size_diff;
    logic [COUNT_BITS-1:0] crcw_diff;
    logic [COUNT_BITS-1:0] size_base;
    logic [COUNT_BITS-1:0] crcw_base;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Position arithmetic for this byte.
    assign cnt_next  = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + COUNT_BITS'(1);
    assign size_base = COUNT_BITS'(size_word_offset);
    assign crcw_base = COUNT_BITS'(crc_word_offset);
    assign size_diff = cnt_reg - size_base;
    assign crcw_diff = cnt_reg - crcw_base;

    // Classify the item.
    always_comb begin
        q_data.data      = in_data;
        q_data.last      = in_last;
        q_data.magic_bad = (cnt_reg < COUNT_BITS'(4)) &&
                           (in_data != fih_pkg::MAGIC[cnt_reg[1:0]]);
        q_data.size_hit  = (cnt_reg >= size_base) && (size_diff < COUNT_BITS'(4));
        q_data.size_rel  = size_diff[1:0];
        q_data.crcw_hit  = (cnt_reg >= crcw_base) && (crcw_diff < COUNT_BITS'(4));
        q_data.crcw_rel  = crcw_diff[1:0];
        q_data.crc_en    = cnt_reg >= COUNT_BITS'(header_bytes);
        q_data.too_small = cnt_next < COUNT_BITS'(min_image_bytes);
        q_data.short4    = cnt_next < COUNT_BITS'(4);
        q_data.saturated = cnt_next == CNT_MAX;
        q_data.length    = 32'(cnt_next);
    end

    // Byte counter, cleared after the last item of an image.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (q_push) begin
            cnt_reg <= in_last ? '0 : cnt_next;
        end
    end

endmodule

FILE: rtl/core/fih_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on fih_pkg.
module fih_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  fih_pkg::q_entry_t   push_data,
    output logic                full,
    input  logic                pop,
    output fih_pkg::q_entry_t   pop_data,
    output logic                empty
);

    fih_pkg::q_entry_t              mem_reg [fih_pkg::QUEUE_DEPTH];
    logic [fih_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [fih_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [fih_pkg::QUEUE_AW:0]     count_reg;

    assign full     = count_reg == (fih_pkg::QUEUE_AW+1)'(fih_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + (fih_pkg::QUEUE_AW)'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + (fih_pkg::QUEUE_AW)'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (fih_pkg::QUEUE_AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (fih_pkg::QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

FILE: rtl/core/fih_back.sv
// Back end of the image header checker: runs the CRC, captures the header words
// and builds the result held in the output register. Depends on fih_pkg.
module fih_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  fih_pkg::q_entry_t   q_data,
    input  logic                q_empty,
    output logic                q_pop,
    input  logic [11:0]         header_bytes,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          status,
    output logic [31:0]         image_length,
    output logic [31:0]         payload_length,
    output logic [31:0]         computed_crc,
    output logic [31:0]         header_crc
);

    logic        crc_en;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] size_reg;
    logic [31:0] size_next;
    logic [31:0] crcw_reg;
    logic [31:0] crcw_next;
    logic        magic_reg;
    logic        magic_next;
    logic [31:0] payload;
    logic [2:0]  status_next;
    logic        load;

    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [31:0] length_reg;
    logic [31:0] payload_reg;
    logic [31:0] ccrc_reg;
    logic [31:0] hcrc_reg;

    // An item leaves the queue unless it is a last item facing a full output.
    assign q_pop = !q_empty && (!q_data.last || !out_valid_reg || out_ready);
    assign load  = q_pop && q_data.last;

    // Per-byte updates of the image state.
    always_comb begin
        crc_en     = q_data.crc_en;
        crc_next   = crc_en ? fih_pkg::crc_byte(crc_reg, q_data.data) : crc_reg;
        size_next  = q_data.size_hit ? fih_pkg::put_byte(size_reg, q_data.size_rel, q_data.data)
                                     : size_reg;
        crcw_next  = q_data.crcw_hit ? fih_pkg::put_byte(crcw_reg, q_data.crcw_rel, q_data.data)
                                     : crcw_reg;
        magic_next = magic_reg && !q_data.magic_bad;
        payload    = q_data.length - 32'(header_bytes);
    end

    // First failing check, in priority order.
    always_comb begin
        if (q_data.too_small) begin
            status_next = fih_pkg::ST_SMALL;
        end else if (!magic_next || q_data.short4) begin
            status_next = fih_pkg::ST_MAGIC;
        end else if (q_data.saturated || size_next != payload) begin
            status_next = fih_pkg::ST_SIZE;
        end else if (crcw_next != crc_next) begin
            status_next = fih_pkg::ST_CRC;
        end else begin
            status_next = fih_pkg::ST_OK;
        end
    end

    // Image state, cleared after the last item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= fih_pkg::CRC_INIT;
            size_reg  <= '0;
            crcw_reg  <= '0;
            magic_reg <= 1'b1;
        end else if (q_pop) begin
            if (q_data.last) begin
                crc_reg   <= fih_pkg::CRC_INIT;
                size_reg  <= '0;
                crcw_reg  <= '0;
                magic_reg <= 1'b1;
            end else begin
                crc_reg   <= crc_next;
                size_reg  <= size_next;
                crcw_reg  <= crcw_next;
                magic_reg <= magic_next;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg  <= status_next;
            length_reg  <= q_data.length;
            payload_reg <= payload;
            ccrc_reg    <= crc_next;
            hcrc_reg    <= crcw_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign image_length   = length_reg;
    assign payload_length = payload_reg;
    assign computed_crc   = ccrc_reg;
    assign header_crc     = hcrc_reg;

endmodule

FILE: rtl/core/firmware_image_header_checker.sv
// Top level of the firmware image header checker: configuration registers,
// front end, item queue and back end. Depends on fih_pkg, fih_front, fih_queue,
// fih_back and firmware_image_header_checker_macros.svh.
//
// The checker takes one image byte per item on the s_ channel, with s_tlast on
// the final byte, and sustains one item per clock cycle while the queue is not
// full. The front end stamps each byte with its position and classification and
// places it in a four-entry queue; the back end applies the byte-wide
// CRC-32/MPEG-2 step and the header word captures to each item that it takes
// from the queue. A result is loaded into an output register when the last byte
// leaves the queue and is held there, so the input keeps flowing while a result
// waits; the back end goes on taking bytes up to the next last byte, and the
// queue then fills to four items, that last byte among them, before s_tready
// drops. The byte counter is COUNT_BITS wide and saturates. There is no clearing
// pass after reset. The user must write configuration over the APB port only
// while no image is in progress; the block itself does not enforce it.
`include "firmware_image_header_checker_macros.svh"

module firmware_image_header_checker #(
    parameter int COUNT_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input items.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] data_byte
    input  logic         s_tlast,    // last_byte
    // Result items.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,    // [2:0] status, [34:3] image_length,
                                     // [66:35] payload_length, [98:67] computed_crc,
                                     // [130:99] header_crc, [135:131] zero
    // Configuration.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [15:0] min_reg;
    logic [11:0] header_reg;
    logic [11:0] size_off_reg;
    logic [11:0] crc_off_reg;
    logic        cfg_wr;

    fih_pkg::q_entry_t push_data;
    fih_pkg::q_entry_t pop_data;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;

    logic [2:0]  status;
    logic [31:0] image_length;
    logic [31:0] payload_length;
    logic [31:0] computed_crc;
    logic [31:0] header_crc;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= fih_pkg::MIN_IMAGE_RST;
            header_reg   <= fih_pkg::HEADER_RST;
            size_off_reg <= fih_pkg::SIZE_OFF_RST;
            crc_off_reg  <= fih_pkg::CRC_OFF_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                fih_pkg::REG_MIN_IMAGE: min_reg      <= pwdata[15:0];
                fih_pkg::REG_HEADER:    header_reg   <= pwdata[11:0];
                fih_pkg::REG_SIZE_OFF:  size_off_reg <= pwdata[11:0];
                fih_pkg::REG_CRC_OFF:   crc_off_reg  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            fih_pkg::REG_MIN_IMAGE: prdata = 32'(min_reg);
            fih_pkg::REG_HEADER:    prdata = 32'(header_reg);
            fih_pkg::REG_SIZE_OFF:  prdata = 32'(size_off_reg);
            fih_pkg::REG_CRC_OFF:   prdata = 32'(crc_off_reg);
            default:                prdata = '0;
        endcase
    end

    // Front end.
    fih_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_data          (s_tdata),
        .in_last          (s_tlast),
        .min_image_bytes  (min_reg),
        .header_bytes     (header_reg),
        .size_word_offset (size_off_reg),
        .crc_word_offset  (crc_off_reg),
        .q_full           (q_full),
        .q_push           (push),
        .q_data           (push_data)
    );

    // Item queue.
    fih_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // Back end.
    fih_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_data         (pop_data),
        .q_empty        (q_empty),
        .q_pop          (pop),
        .header_bytes   (header_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .status         (status),
        .image_length   (image_length),
        .payload_length (payload_length),
        .computed_crc   (computed_crc),
        .header_crc     (header_crc)
    );

    assign m_tdata = {5'b0, header_crc, computed_crc, payload_length, image_length, status};

    // The payload length always follows from the image length and header size.
    `FIH_ASSERT_IMP(a_payload_len, aclk, aresetn, m_tvalid,
        payload_length == (image_length - 32'(header_reg)))
    // A good result implies matching CRC words.
    `FIH_ASSERT_IMP(a_ok_crc, aclk, aresetn, m_tvalid && (status == fih_pkg::ST_OK),
        computed_crc == header_crc)
    // A good result implies an image at least the minimum length.
    `FIH_ASSERT_IMP(a_ok_len, aclk, aresetn, m_tvalid && (status == fih_pkg::ST_OK),
        image_length >= 32'(min_reg))
    // A pop without a waiting item would corrupt the queue pointers.
    `FIH_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, pop, !q_empty)

endmodule

FILE: sim/fih_verdict_checker.sv
`timescale 1ns / 100ps
// Checker for the firmware image header checker: it tracks register writes, predicts
// the verdict of every image from the accepted bytes and compares the result items.
// Depends on fih_pkg; also holds fih_tb_pkg, which the testbench top uses as well.

package fih_tb_pkg;

    import fih_pkg::*;

    // One expected verdict, in the field order of the result item.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] image_length;
        logic [31:0] payload_length;
        logic [31:0] computed_crc;
        logic [31:0] header_crc;
    } image_verdict_t;

    // CRC-32/MPEG-2 over one byte, most significant data bit first.
    function automatic logic [31:0] crc32_mpeg2_step(input logic [31:0] crc,
                                                     input logic [7:0] d);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[31] ^ d[i];
            c  = {c[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

module fih_verdict_checker #(
    parameter int COUNT_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] data_byte
    input  logic         s_tlast,    // last_byte
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,    // [2:0] status, [34:3] image_length,
                                     // [66:35] payload_length, [98:67] computed_crc,
                                     // [130:99] header_crc, [135:131] zero
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic [31:0]  prdata,
    input  logic         pready,
    output int           failures,
    output int           pending,
    output int           verdicts_checked,
    output logic [4:0]   status_seen
);

    import fih_pkg::*;
    import fih_tb_pkg::*;

    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    // Shadow copy of the configuration registers.
    logic [15:0] min_len;
    logic [11:0] hdr_len;
    logic [11:0] size_off;
    logic [11:0] crc_off;

    // Per-image state of the prediction.
    logic [31:0] byte_pos;
    logic [31:0] crc_acc;
    logic [31:0] size_word;
    logic [31:0] crc_word;
    logic        magic_ok;

    image_verdict_t verdicts_due[$];

    // Counts a mismatch and prints one line for it.
    task report_mismatch(input string msg);
        failures++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task compare_field(input string name, input logic [31:0] got_v, input logic [31:0] want_v);
        if (got_v !== want_v) begin
            report_mismatch($sformatf("result %0d: %s is %h, expected %h",
                                      verdicts_checked, name, got_v, want_v));
        end
    endtask

    // Replaces one byte of a little-endian header word when the byte falls inside it.
    function automatic logic [31:0] place_le(input logic [31:0] word, input logic [31:0] pos,
                                             input logic [11:0] base, input logic [7:0] b);
        logic [31:0] rel;
        logic [31:0] w;
        w   = word;
        rel = pos - {20'd0, base};
        if (pos >= {20'd0, base} && rel < 32'd4) begin
            w[{rel[1:0], 3'b000} +: 8] = b;
        end
        return w;
    endfunction

    function void clear_image();
        byte_pos  = '0;
        crc_acc   = CRC_INIT;
        size_word = '0;
        crc_word  = '0;
        magic_ok  = 1'b1;
    endfunction

    // Folds one accepted byte into the image state; the last byte yields a verdict.
    task absorb_byte(input logic [7:0] b, input logic last_in);
        image_verdict_t v;
        if (byte_pos < 32'd4 && b != MAGIC[byte_pos[1:0]]) begin
            magic_ok = 1'b0;
        end
        size_word = place_le(size_word, byte_pos, size_off, b);
        crc_word  = place_le(crc_word, byte_pos, crc_off, b);
        if (byte_pos >= {20'd0, hdr_len}) begin
            crc_acc = crc32_mpeg2_step(crc_acc, b);
        end
        if (byte_pos < COUNT_MAX) begin
            byte_pos = byte_pos + 32'd1;
        end
        if (last_in) begin
            v.image_length   = byte_pos;
            v.payload_length = byte_pos - {20'd0, hdr_len};
            v.computed_crc   = crc_acc;
            v.header_crc     = crc_word;
            // The first failing check wins.
            if (byte_pos < {16'd0, min_len}) begin
                v.status = ST_SMALL;
            end else if (!magic_ok || byte_pos < 32'd4) begin
                v.status = ST_MAGIC;
            end else if (byte_pos == COUNT_MAX || size_word != v.payload_length) begin
                v.status = ST_SIZE;
            end else if (crc_word != crc_acc) begin
                v.status = ST_CRC;
            end else begin
                v.status = ST_OK;
            end
            verdicts_due.push_back(v);
            clear_image();
        end
    endtask

    // Compares one result item with the oldest outstanding verdict.
    task check_verdict();
        image_verdict_t want;
        if (verdicts_due.size() == 0) begin
            report_mismatch("result item arrived with no image outstanding");
        end else begin
            want = verdicts_due.pop_front();
            compare_field("status", {29'd0, m_tdata[2:0]}, {29'd0, want.status});
            compare_field("image_length", m_tdata[34:3], want.image_length);
            compare_field("payload_length", m_tdata[66:35], want.payload_length);
            compare_field("computed_crc", m_tdata[98:67], want.computed_crc);
            compare_field("header_crc", m_tdata[130:99], want.header_crc);
            compare_field("padding", {27'd0, m_tdata[135:131]}, 32'd0);
        end
        if (m_tdata[2:0] <= ST_CRC) begin
            status_seen[m_tdata[2:0]] = 1'b1;
        end
        verdicts_checked++;
    endtask

    task write_register(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            REG_MIN_IMAGE: min_len  = data[15:0];
            REG_HEADER:    hdr_len  = data[11:0];
            REG_SIZE_OFF:  size_off = data[11:0];
            REG_CRC_OFF:   crc_off  = data[11:0];
            default: ;
        endcase
    endtask

    task check_readback(input logic [1:0] idx, input logic [31:0] data);
        logic [31:0] want;
        case (idx)
            REG_MIN_IMAGE: want = {16'd0, min_len};
            REG_HEADER:    want = {20'd0, hdr_len};
            REG_SIZE_OFF:  want = {20'd0, size_off};
            default:       want = {20'd0, crc_off};
        endcase
        if (data !== want) begin
            report_mismatch($sformatf("register %0d reads %h, expected %h", idx, data, want));
        end
    endtask

    // Everything is sampled at the rising edge, where the bus values are settled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            min_len  = MIN_IMAGE_RST;
            hdr_len  = HEADER_RST;
            size_off = SIZE_OFF_RST;
            crc_off  = CRC_OFF_RST;
            clear_image();
            verdicts_due.delete();
            failures         = 0;
            verdicts_checked = 0;
            status_seen      = '0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    write_register(paddr[3:2], pwdata);
                end else begin
                    check_readback(paddr[3:2], prdata);
                end
            end
            if (m_tvalid && m_tready) begin
                check_verdict();
            end
            if (s_tvalid && s_tready) begin
                absorb_byte(s_tdata, s_tlast);
            end
        end
        pending <= verdicts_due.size();
    end

endmodule

FILE: sim/tb_firmware_image_header_checker.sv
`timescale 1ns / 100ps
// Testbench top for the firmware image header checker: clock, reset, image stimulus,
// register programming and the verdict. Depends on fih_pkg and fih_verdict_checker.

module tb_firmware_image_header_checker;

    import fih_pkg::*;
    import fih_tb_pkg::*;

    // A narrower counter than the default exercises the width parameter.
    localparam int COUNT_BITS   = 16;
    localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
    localparam int ITEM_TARGET  = 1000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 800000;

    // Ways a well-formed image can be damaged on purpose.
    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_SIZE,
        FLAW_CRC,
        FLAW_SHORT
    } flaw_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;     // [7:0] data_byte
    logic         s_tlast;     // last_byte
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;     // [2:0] status, [34:3] image_length,
                               // [66:35] payload_length, [98:67] computed_crc,
                               // [130:99] header_crc, [135:131] zero
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int           failures;
    int           pending;
    int           verdicts_checked;
    logic [4:0]   status_seen;

    // Stimulus state.
    logic [7:0]   image_bytes[$];
    int           cfg_hdr;
    int           cfg_size_off;
    int           cfg_crc_off;
    int           bytes_sent = 0;
    int           images_sent = 0;
    int           random_items = 0;
    int           config_phases = 0;
    bit           steady_input = 1'b0;
    bit           steady_output = 1'b0;
    bit           hold_req = 1'b0;

    firmware_image_header_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    fih_verdict_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) verdict_chk (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .failures(failures),
        .pending(pending),
        .verdicts_checked(verdicts_checked),
        .status_seen(status_seen)
    );

    // Clock with an 8 ns period.
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Idle length: mostly none, sometimes a few cycles, rarely a long stretch.
    function automatic int idle_cycles(input bit steady);
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // One APB transfer: a setup cycle, then the access cycle.
    task apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes all four registers, then reads them back for the checker.
    task set_config(input int mn, input int hdr, input int so, input int co);
        cfg_hdr      = hdr;
        cfg_size_off = so;
        cfg_crc_off  = co;
        apb_access(1'b1, REG_MIN_IMAGE, mn);
        apb_access(1'b1, REG_HEADER, hdr);
        apb_access(1'b1, REG_SIZE_OFF, so);
        apb_access(1'b1, REG_CRC_OFF, co);
        apb_access(1'b0, REG_MIN_IMAGE, 32'd0);
        apb_access(1'b0, REG_HEADER, 32'd0);
        apb_access(1'b0, REG_SIZE_OFF, 32'd0);
        apb_access(1'b0, REG_CRC_OFF, 32'd0);
        config_phases++;
    endtask

    // Offers one item and waits for its handshake, then maybe idles.
    task send_byte(input logic [7:0] b, input logic last_in);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last_in;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = idle_cycles(steady_input);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task send_image();
        for (int k = 0; k < image_bytes.size(); k++) begin
            send_byte(image_bytes[k], k == image_bytes.size() - 1);
        end
        bytes_sent += image_bytes.size();
        images_sent++;
    endtask

    // Drops the input and waits until every verdict is back and the block is quiet.
    task settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task put_word(input int offset, input logic [31:0] value);
        for (int k = 0; k < 4; k++) begin
            if (offset + k < image_bytes.size()) begin
                image_bytes[offset + k] = value[8*k +: 8];
            end
        end
    endtask

    // Random bytes, optionally starting with as much of the magic as fits.
    task build_noise(input int len, input bit magic_front);
        image_bytes.delete();
        for (int k = 0; k < len; k++) begin
            image_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (magic_front) begin
            for (int k = 0; k < 4 && k < len; k++) begin
                image_bytes[k] = MAGIC[k];
            end
        end
    endtask

    // An image laid out for the current registers, with at most one flaw.
    task build_frame(input int plen, input flaw_t flaw);
        logic [31:0] word;
        int          k;
        build_noise(cfg_hdr + plen, 1'b1);
        word = plen;
        if (flaw == FLAW_SIZE) begin
            word = word ^ (32'd1 << $urandom_range(0, 31));
        end
        put_word(cfg_size_off, word);
        word = CRC_INIT;
        for (k = cfg_hdr; k < image_bytes.size(); k++) begin
            word = crc32_mpeg2_step(word, image_bytes[k]);
        end
        if (flaw == FLAW_CRC) begin
            word = word ^ (32'd1 << $urandom_range(0, 31));
        end
        put_word(cfg_crc_off, word);
        if (flaw == FLAW_MAGIC) begin
            k = $urandom_range(0, 3);
            image_bytes[k] = image_bytes[k] ^ (8'd1 << $urandom_range(0, 7));
        end
        if (flaw == FLAW_SHORT) begin
            repeat ($urandom_range(1, 4)) begin
                if (image_bytes.size() > 1) begin
                    void'(image_bytes.pop_back());
                end
            end
        end
    endtask

    // Result side: random back-pressure, plus a long hold when requested.
    initial begin
        int n;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                n = idle_cycles(steady_output);
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Run limit.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("firmware_image_header_checker: mismatch");
        $finish;
    end

    // Main stimulus.
    initial begin
        int    r;
        int    hdr;
        int    so;
        int    co;
        int    plen;
        flaw_t flaw;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 4'd0;
        pwdata   <= 32'd0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: a short image is too small and ends before the header words.
        build_noise(5, 1'b1);
        send_image();
        settle();

        // Directed: a valid image with an empty payload, then short and odd images.
        set_config(0, 12, 4, 8);
        build_frame(0, FLAW_NONE);
        send_image();
        image_bytes.delete();
        image_bytes.push_back(8'hff);
        send_image();
        build_noise(3, 1'b1);
        send_image();
        build_noise(7, 1'b1);
        image_bytes[4] = 8'h00;
        image_bytes[5] = 8'hff;
        image_bytes[6] = 8'h00;
        send_image();
        settle();

        // All registers at zero: header words overlap the magic, the CRC covers all.
        set_config(0, 0, 0, 0);
        repeat (6) begin
            build_noise($urandom_range(1, 20), 1'($urandom_range(0, 1)));
            send_image();
        end
        settle();

        // All registers at their maximum: every image ends inside the header.
        set_config(16'hffff, 12'hfff, 12'hfff, 12'hfff);
        repeat (3) begin
            build_noise($urandom_range(1, 20), 1'($urandom_range(0, 1)));
            send_image();
        end
        settle();

        // Random phases: mostly laid-out images, some damaged, some plain noise.
        while (random_items < ITEM_TARGET) begin
            hdr = $urandom_range(12, 32);
            if ($urandom_range(0, 3) == 0) begin
                so = $urandom_range(0, hdr + 8);
                co = $urandom_range(0, hdr + 8);
            end else begin
                so = $urandom_range(4, hdr - 8);
                co = $urandom_range(so + 4, hdr - 4);
                if ($urandom_range(0, 1) == 1) begin
                    r  = so;
                    so = co;
                    co = r;
                end
            end
            set_config($urandom_range(0, hdr + 30), hdr, so, co);
            // The first random phase sends without gaps so the long hold backs up the input.
            steady_input  = (config_phases == 4) || ($urandom_range(0, 3) == 0);
            steady_output = ($urandom_range(0, 3) == 0);
            // The receiver holds off long enough for the input to back up.
            if (config_phases == 4 || $urandom_range(0, 4) == 0) begin
                hold_req = 1'b1;
            end
            repeat ($urandom_range(8, 14)) begin
                if ($urandom_range(0, 99) < 70) begin
                    r = $urandom_range(0, 99);
                    if (r < 60) begin
                        flaw = FLAW_NONE;
                    end else if (r < 70) begin
                        flaw = FLAW_MAGIC;
                    end else if (r < 80) begin
                        flaw = FLAW_SIZE;
                    end else if (r < 90) begin
                        flaw = FLAW_CRC;
                    end else begin
                        flaw = FLAW_SHORT;
                    end
                    plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
                    build_frame(plen, flaw);
                end else begin
                    build_noise($urandom_range(1, 40), 1'($urandom_range(0, 1)));
                end
                random_items += image_bytes.size();
                send_image();
            end
            settle();
        end

        $display("Sent %0d images (%0d bytes) over %0d register settings; %0d results checked.",
                 images_sent, bytes_sent, config_phases, verdicts_checked);
        $display("Status codes seen, one bit per code from ok upward: %05b; count limit %0d.",
                 status_seen, COUNT_MAX);
        if (failures == 0 && pending == 0) begin
            $display("firmware_image_header_checker: match");
        end else begin
            $display("firmware_image_header_checker: mismatch");
        end
        $finish;
    end

endmodule
